// ----- hdl/fcma_pkg.sv -----
package fcma_pkg;

  // Window length and derived widths
  localparam int WINDOW = 16;
  localparam int CHANS  = 4;
  localparam int PIX_W  = 8;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = PIX_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);
  localparam int DATA_W = CHANS * PIX_W;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [DATA_W-1:0] data_t;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/fcma_div.sv -----
module fcma_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fcma_pkg::sum_t      dividend [fcma_pkg::CHANS],
  input  fcma_pkg::cnt_t      divisor,
  output fcma_pkg::pix_t      quot [fcma_pkg::CHANS],
  output fcma_pkg::div_stat_t stat
);
  import fcma_pkg::*;

  // Four restoring divider lanes sharing one divisor and step counter
  sum_t  q      [CHANS];
  cnt_t  rem    [CHANS];
  sum_t  q_next [CHANS];
  cnt_t  rem_next [CHANS];
  cnt_t  dvs;
  step_t step;
  logic  busy;
  logic  done;

  // One quotient bit per lane per cycle while busy
  always_comb begin
    logic [CNT_W:0] trial;
    for (int c = 0; c < CHANS; c++) begin
      trial = {rem[c], q[c][SUM_W-1]};
      if (trial >= {1'b0, dvs}) begin
        rem_next[c] = CNT_W'(trial - {1'b0, dvs});
        q_next[c]   = {q[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[c] = trial[CNT_W-1:0];
        q_next[c]   = {q[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Lane datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int c = 0; c < CHANS; c++) begin
        q[c]   <= dividend[c];
        rem[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < CHANS; c++) begin
        q[c]   <= q_next[c];
        rem[c] <= rem_next[c];
      end
    end
  end

  // Mean of 8-bit values fits in the low bits of the quotient
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      quot[c] = q[c][PIX_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- hdl/four_channel_moving_average_core.sv -----
// Channel | Dir | Bus               | Contents
// sample  | in  | s_tvalid/tready   | s_tdata: red, green, blue, alpha (8 bits each)
// mean    | out | m_tvalid/tready   | m_tdata: red, green, blue, alpha means
//
// One item at a time; the result comes from the bit-serial divider, one quotient
// bit a cycle for all four channels at once. The ring is one memory read at
// accept and written back in the following cycle with the running sums updated
// alongside.
// Reset clears slot, fill count, running sums and control; ring contents
// need no clearing. A result held on a stalled output does not block the
// next item from being accepted and worked on.
module four_channel_moving_average_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  fcma_pkg::data_t       s_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output fcma_pkg::data_t       m_tdata    // red_avg, green_avg, blue_avg, alpha_avg
);
  import fcma_pkg::*;

  state_t    state;
  state_t    state_next;
  data_t     ring [WINDOW];
  data_t     rd_q;
  data_t     sample;
  slot_t     write_slot;
  cnt_t      fill_count;
  cnt_t      fill_count_next;
  sum_t      sum      [CHANS];
  sum_t      sum_next [CHANS];
  pix_t      quot     [CHANS];
  logic      full;
  logic      accept;
  logic      out_free;
  logic      div_start;
  logic      load_out;
  div_stat_t div_stat;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (fill_count == CNT_W'(WINDOW));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring memory: read at the current slot, written back in the load cycle
  always_ff @(posedge clk) begin
    rd_q <= ring[write_slot];
    if (state == ST_LOAD) begin
      ring[write_slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) sample <= s_tdata;
  end

  // Running sums: add the new sample, drop the oldest once the ring is full
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      sum_next[c] = sum[c] + SUM_W'(sample[c*PIX_W +: PIX_W])
                  - (full ? SUM_W'(rd_q[c*PIX_W +: PIX_W]) : SUM_W'(0));
    end
    fill_count_next = full ? fill_count : fill_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      for (int c = 0; c < CHANS; c++) sum[c] <= '0;
    end else if (state == ST_LOAD) begin
      write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
      fill_count <= fill_count_next;
      for (int c = 0; c < CHANS; c++) sum[c] <= sum_next[c];
    end
  end

  fcma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (fill_count_next),
    .quot     (quot),
    .stat     (div_stat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int c = 0; c < CHANS; c++) m_tdata[c*PIX_W +: PIX_W] <= quot[c];
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside divide phase");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOAD && div_stat.busy == 1'b0)
    else $error("accepted item not followed by ring update");

  a_busy_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIV)
    else $error("divider running outside divide phase");

endmodule

// ----- tb/tb_four_channel_moving_average_core.sv -----
`timescale 1ns / 100ps

module tb_four_channel_moving_average_core;
  import fcma_pkg::*;

  logic  clk      = 1'b0;
  logic  rst      = 1'b1;
  logic  s_tvalid = 1'b0;
  logic  s_tready;
  data_t s_tdata  = '0;  // red_in, green_in, blue_in, alpha_in
  logic  m_tvalid;
  logic  m_tready = 1'b0;
  data_t m_tdata;        // red_avg, green_avg, blue_avg, alpha_avg

  // Idle chances in percent, changed per traffic phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;

  // Window history and running sums per channel
  pix_t        hist_ring [CHANS][WINDOW];
  slot_t       next_slot = '0;
  int unsigned filled    = 0;
  int unsigned chan_sum [CHANS] = '{default: 0};

  // Means still owed by the block, oldest first
  data_t mean_queue [$];
  data_t owed_mean;

  four_channel_moving_average_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("four_channel_moving_average_core: mismatch");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each delivered mean with the oldest one owed
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (mean_queue.size() == 0) begin
        $display("%0t: unexpected mean, expected none actual %08h", $realtime, m_tdata);
        fail_count++;
      end else begin
        owed_mean = mean_queue.pop_front();
        for (int c = 0; c < CHANS; c++) begin
          if (m_tdata[c*PIX_W +: PIX_W] !== owed_mean[c*PIX_W +: PIX_W]) begin
            $display("%0t: channel %0d mean, expected %02h actual %02h", $realtime, c,
                     owed_mean[c*PIX_W +: PIX_W], m_tdata[c*PIX_W +: PIX_W]);
            fail_count++;
          end
        end
      end
    end
  end

  // Store one sample in the window and work out the four means
  task automatic record_sample(input data_t sample, output data_t mean);
    pix_t level;
    begin
      if (filled == WINDOW) begin
        for (int c = 0; c < CHANS; c++)
          chan_sum[c] -= hist_ring[c][next_slot];
      end else begin
        filled++;
      end
      for (int c = 0; c < CHANS; c++) begin
        level = sample[c*PIX_W +: PIX_W];
        hist_ring[c][next_slot] = level;
        chan_sum[c] += level;
        mean[c*PIX_W +: PIX_W] = pix_t'(chan_sum[c] / filled);
      end
      next_slot = (next_slot == slot_t'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
    end
  endtask

  // Offer one item; entered and left at a falling edge
  task automatic send_sample(input data_t sample);
    data_t mean;
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= sample;
      do @(posedge clk); while (!s_tready);
      record_sample(sample, mean);
      mean_queue.push_back(mean);
      @(negedge clk);
    end
  endtask

  // Hold the sender off until every owed mean has been delivered
  task automatic wait_for_means();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (mean_queue.size() != 0) @(negedge clk);
  endtask

  function automatic data_t pack_sample(pix_t r, pix_t g, pix_t b, pix_t a);
    return {a, b, g, r};
  endfunction

  // Mostly uniform, with the extremes favoured to push the sums to their limits
  function automatic pix_t rand_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  // Warm-up: divisor follows the fill count, extremes and alternating bits
  task automatic test_warmup_extremes();
    send_sample(pack_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_sample(pack_sample(8'h00, 8'h00, 8'h00, 8'h00));
    send_sample(pack_sample(8'hAA, 8'h55, 8'h01, 8'h80));
    send_sample(pack_sample(8'h55, 8'hAA, 8'hFE, 8'h7F));
    send_sample(pack_sample(8'h00, 8'hFF, 8'h00, 8'hFF));
    send_sample(pack_sample(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_sample(pack_sample(8'h01, 8'h02, 8'h03, 8'h04));
    send_sample(pack_sample(8'h10, 8'h20, 8'h40, 8'h80));
  endtask

  // Fill count saturates and the write slot wraps over old entries
  task automatic test_window_wrap();
    for (int i = 0; i < 10; i++)
      send_sample(pack_sample(pix_t'(i * 17), pix_t'(255 - i * 13),
                              pix_t'(i * 29), pix_t'(8'hF0 ^ i)));
    send_sample(pack_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_sample(pack_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Random samples under a given idle pattern
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // a full window of saturated samples now and then
      if ($urandom_range(39) == 0) begin
        for (int k = 0; k < WINDOW; k++)
          send_sample(pack_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        i += WINDOW - 1;
      end else begin
        send_sample(pack_sample(rand_level(), rand_level(), rand_level(), rand_level()));
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_warmup_extremes();
    test_window_wrap();
    wait_for_means();

    test_random_traffic(135, 0, 0);
    test_random_traffic(135, 54, 0);
    test_random_traffic(135, 0, 54);
    wait_for_means();
    test_random_traffic(135, 32, 32);

    wait_for_means();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("four_channel_moving_average_core: match");
    end else begin
      $display("four_channel_moving_average_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- four_channel_moving_average_core.f -----
hdl/fcma_pkg.sv
hdl/fcma_div.sv
hdl/four_channel_moving_average_core.sv
tb/tb_four_channel_moving_average_core.sv
